>>> rtl/wrm_pkg.sv
// Shared constants, mode codes and the lane control bundle of the windowed meter.
`timescale 1ns / 1ps
package wrm_pkg;
  localparam int NUM_CH      = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 20;
  localparam int ACC_BITS    = 2 * SAMPLE_BITS + COUNT_BITS - 1;
  localparam int RESULT_BITS = SAMPLE_BITS + 1;
  localparam int ROOT_BITS   = (ACC_BITS + 1) / 2;
  localparam int ITER_BITS   = $clog2(ACC_BITS + 1);
  localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(24000);

  typedef enum logic [1:0] {
    MODE_RMS = 2'd0,
    MODE_AVG = 2'd1,
    MODE_MAX = 2'd2,
    MODE_MIN = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_MODE   = 1'b0,
    CFG_WINDOW = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                  load;
    logic                  square;
    logic                  add;
    logic                  fin;
    logic                  clear;
    logic                  first;
    mode_t                 mode;
    logic [COUNT_BITS-1:0] count;
  } lane_ctl_t;
endpackage

>>> rtl/wrm_lane.sv
// One channel lane: accumulator, restoring divider and bit-serial square root.
`timescale 1ns / 1ps
module wrm_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wrm_pkg::lane_ctl_t                    ctl,
  input  logic signed [wrm_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                  busy,
  output logic        [wrm_pkg::RESULT_BITS-1:0] result
);
  localparam int AB = wrm_pkg::ACC_BITS;
  localparam int CB = wrm_pkg::COUNT_BITS;
  localparam int RB = wrm_pkg::ROOT_BITS;
  localparam int IB = wrm_pkg::ITER_BITS;

  typedef enum logic [1:0] {L_IDLE, L_DIV, L_SQRT} lstate_t;

  lstate_t                         state_r;
  logic signed [wrm_pkg::SAMPLE_BITS-1:0] samp_r;
  logic [AB-1:0]                   term_r, acc_r, quo_r;
  logic [CB-1:0]                   rem_r, den_r;
  logic [2*RB-1:0]                 x_r;
  logic [RB-1:0]                   root_r;
  logic [RB+1:0]                   srem_r;
  logic [IB-1:0]                   cnt_r;
  logic                            neg_r, rms_r;
  logic [wrm_pkg::RESULT_BITS-1:0] res_r;

  logic signed [AB-1:0] samp_ext;
  logic signed [2*wrm_pkg::SAMPLE_BITS-1:0] sq_w;
  logic [CB:0]          dtrial;
  logic                 dbit;
  logic [RB+2:0]        strial_src;
  logic [RB+2:0]        strial;
  logic                 sbit;
  logic [AB-1:0]        quo_nxt;

  always_comb begin
    samp_ext   = AB'(samp_r);
    sq_w       = samp_r * samp_r;
    dtrial     = {rem_r, quo_r[AB-1]};
    dbit       = (dtrial >= {1'b0, den_r});
    quo_nxt    = {quo_r[AB-2:0], dbit};
    strial_src = {srem_r[RB:0], x_r[2*RB-1 -: 2]};
    strial     = (RB+3)'({root_r, 2'b01});
    sbit       = (strial_src >= strial);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      samp_r <= sample;
    end
    if (ctl.square) begin
      if (ctl.mode == wrm_pkg::MODE_RMS) begin
        term_r <= AB'($unsigned(sq_w));
      end else begin
        term_r <= samp_ext;
      end
    end
    if (!rst_n || ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.add) begin
      case (ctl.mode)
        wrm_pkg::MODE_RMS, wrm_pkg::MODE_AVG: acc_r <= acc_r + term_r;
        wrm_pkg::MODE_MAX: if (ctl.first || samp_ext > $signed(acc_r)) acc_r <= samp_ext;
        default:           if (ctl.first || samp_ext < $signed(acc_r)) acc_r <= samp_ext;
      endcase
    end else if (ctl.fin) begin
      acc_r <= '0;
    end

    if (!rst_n) begin
      state_r <= L_IDLE;
      res_r   <= '0;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (ctl.fin) begin
            if (ctl.mode == wrm_pkg::MODE_RMS || ctl.mode == wrm_pkg::MODE_AVG) begin
              neg_r   <= (ctl.mode == wrm_pkg::MODE_AVG) && acc_r[AB-1];
              quo_r   <= ((ctl.mode == wrm_pkg::MODE_AVG) && acc_r[AB-1]) ? -acc_r : acc_r;
              rms_r   <= (ctl.mode == wrm_pkg::MODE_RMS);
              den_r   <= ctl.count;
              rem_r   <= '0;
              cnt_r   <= IB'(AB - 1);
              state_r <= L_DIV;
            end else begin
              res_r <= acc_r[wrm_pkg::RESULT_BITS-1:0];
            end
          end
        end
        L_DIV: begin
          rem_r <= dbit ? CB'(dtrial - {1'b0, den_r}) : dtrial[CB-1:0];
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            if (rms_r) begin
              x_r     <= (2*RB)'(quo_nxt);
              root_r  <= '0;
              srem_r  <= '0;
              cnt_r   <= IB'(RB - 1);
              state_r <= L_SQRT;
            end else begin
              res_r   <= neg_r ? -quo_nxt[wrm_pkg::RESULT_BITS-1:0]
                               : quo_nxt[wrm_pkg::RESULT_BITS-1:0];
              state_r <= L_IDLE;
            end
          end
        end
        L_SQRT: begin
          srem_r <= sbit ? (RB+2)'(strial_src - strial) : strial_src[RB+1:0];
          root_r <= {root_r[RB-2:0], sbit};
          x_r    <= {x_r[2*RB-3:0], 2'b00};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            res_r   <= wrm_pkg::RESULT_BITS'({root_r[RB-2:0], sbit});
            state_r <= L_IDLE;
          end
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign busy   = (state_r != L_IDLE);
  assign result = res_r;
endmodule

>>> rtl/windowed_rms_avg_min_max_top.sv
// Top level of the four-channel windowed RMS, average, maximum and minimum meter.
`timescale 1ns / 1ps
// How to use this block:
// The input channel (in_valid, in_ready, in_sample_ch0..3) takes one item per
// frame, one signed Q1.15 sample per channel. Each accepted item yields exactly
// one result item on the output channel (out_valid, out_ready, out_result_ch0..3,
// out_result_valid) carrying the held per-channel measures.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes measure_mode at
// index 0 and window_length at index 1; write only while idle.
// A mode write clears the accumulators and the frame counter.
// An item that does not close a window passes through the sample latch, square,
// accumulate and output load steps. An item that closes a window in average mode
// then runs the lane divider, one quotient bit per cycle; rms mode adds the root
// unit, one root bit per cycle; maximum and minimum skip both. All four lanes run
// their dividers and roots side by side, so the finalize time does not grow with
// the channel count. One item is processed at a time; the next item can be
// accepted in the cycle after the result is loaded.
// The output register lets a new item be accepted while the last result waits;
// when the receiver stalls, the next result waits in its final state.
// Reset (rst_n low, synchronous) clears mode to rms, window to 24000 frames,
// all accumulators, the lane results and the valid flags; out_result_ch0..3 are not reset.
module windowed_rms_avg_min_max_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [wrm_pkg::SAMPLE_BITS-1:0] in_sample_ch0,
  input  logic signed [wrm_pkg::SAMPLE_BITS-1:0] in_sample_ch1,
  input  logic signed [wrm_pkg::SAMPLE_BITS-1:0] in_sample_ch2,
  input  logic signed [wrm_pkg::SAMPLE_BITS-1:0] in_sample_ch3,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [wrm_pkg::RESULT_BITS-1:0] out_result_ch0,
  output logic signed [wrm_pkg::RESULT_BITS-1:0] out_result_ch1,
  output logic signed [wrm_pkg::RESULT_BITS-1:0] out_result_ch2,
  output logic signed [wrm_pkg::RESULT_BITS-1:0] out_result_ch3,
  output logic                                   out_result_valid,
  input  logic                                   cfg_we,
  input  logic                                   cfg_index,
  input  logic        [wrm_pkg::COUNT_BITS-1:0]  cfg_wdata
);
  localparam int CB = wrm_pkg::COUNT_BITS;
  localparam int NC = wrm_pkg::NUM_CH;
  localparam int RB = wrm_pkg::RESULT_BITS;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_ADD, S_FIN0, S_FIN, S_OUT} state_t;

  state_t                state_r;
  wrm_pkg::mode_t        mode_r;
  logic [CB-1:0]         win_r, fc_r, count_r;
  logic                  end_r, have_r, out_valid_r, out_have_r;
  logic [RB-1:0]         out_res_r [NC];

  wrm_pkg::lane_ctl_t          ctl;
  logic signed [wrm_pkg::SAMPLE_BITS-1:0] samples [NC];
  logic [NC-1:0]               busy;
  logic [RB-1:0]               lane_res [NC];
  logic [CB:0]                 count_w, limit_w;
  logic                        accept, mode_wr;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign mode_wr  = cfg_we && (cfg_index == wrm_pkg::CFG_MODE);
  assign count_w  = {1'b0, fc_r} + 1'b1;
  assign limit_w  = (win_r == '0) ? (CB+1)'(1) : {1'b0, win_r};

  assign samples[0] = in_sample_ch0;
  assign samples[1] = in_sample_ch1;
  assign samples[2] = in_sample_ch2;
  assign samples[3] = in_sample_ch3;

  always_comb begin
    ctl        = '0;
    ctl.load   = accept;
    ctl.square = (state_r == S_SQ);
    ctl.add    = (state_r == S_ADD);
    ctl.fin    = (state_r == S_FIN0);
    ctl.clear  = mode_wr;
    ctl.first  = (fc_r == '0);
    ctl.mode   = mode_r;
    ctl.count  = count_r;
  end

  for (genvar g = 0; g < NC; g++) begin : g_lane
    wrm_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .sample (samples[g]),
      .busy   (busy[g]),
      .result (lane_res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= wrm_pkg::MODE_RMS;
      win_r       <= wrm_pkg::WINDOW_RESET;
      fc_r        <= '0;
      end_r       <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_have_r  <= 1'b0;
    end else begin
      // A result taken while the next one loads is replaced in the S_OUT arm.
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          wrm_pkg::CFG_MODE: begin
            mode_r <= wrm_pkg::mode_t'(cfg_wdata[1:0]);
            fc_r   <= '0;
          end
          default: win_r <= cfg_wdata;
        endcase
      end
      case (state_r)
        S_IDLE: if (accept) state_r <= S_SQ;
        S_SQ:   state_r <= S_ADD;
        S_ADD: begin
          // The window closes when this frame brings the count to or past the limit.
          count_r <= count_w[CB-1:0];
          if (count_w >= limit_w) begin
            fc_r    <= '0;
            end_r   <= 1'b1;
            have_r  <= 1'b1;
            state_r <= S_FIN0;
          end else begin
            fc_r    <= count_w[CB-1:0];
            end_r   <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_FIN0: state_r <= S_FIN;
        S_FIN:  if (busy == '0) state_r <= S_OUT;
        S_OUT: begin
          // Wait here while the previous result has not been taken.
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_have_r  <= have_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      for (int c = 0; c < NC; c++) begin
        out_res_r[c] <= lane_res[c];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_ch0   = out_res_r[0];
  assign out_result_ch1   = out_res_r[1];
  assign out_result_ch2   = out_res_r[2];
  assign out_result_ch3   = out_res_r[3];
  assign out_result_valid = out_have_r;

  // Lane dividers and roots run only while the block waits for them.
  a_busy_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (busy != '0) |-> (state_r == S_FIN))
    else $error("lane busy outside finalize");

  // Once a window has completed, the valid flag stays set until reset.
  a_have_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |=> have_r)
    else $error("have flag dropped");

  // Finalize is entered only at a window end, which always passes through it before the output load.
  a_end_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN0) |-> end_r)
    else $error("finalize without window end");
endmodule
